>>> rtl/brbq_pkg.sv
// brbq_pkg: shared types and constants of the byte ring buffer queue
// opcode and status codes, command and result records, back-end states
// no dependencies
`default_nettype none

package brbq_pkg;

  // fixed field widths of the request and result ports
  localparam int unsigned OP_W   = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned DENQ_W = 13;

  // entries of the command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;

  // index advance: index plus count stays below 2**ADV_SUM_W, and a reciprocal
  // of DEPTH scaled by 2**RECIP_SHIFT gives an exact quotient over that range
  // (DEPTH of at least 4 keeps the reciprocal within RECIP_W bits)
  localparam int unsigned ADV_SUM_W   = CNT_W + 1;
  localparam int unsigned RECIP_SHIFT = 2 * CNT_W + 1;
  localparam int unsigned RECIP_W     = RECIP_SHIFT - 1;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_ADV_WR = 3'd3,
    OP_ADV_RD = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_QUERY  = 3'd6
  } op_e;

  // decoded command kind, unused opcodes become a no-op
  typedef enum logic [2:0] {
    K_ENQ,
    K_DEQ,
    K_PEEK,
    K_ADV_WR,
    K_ADV_RD,
    K_CLEAR,
    K_QUERY,
    K_NOP
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ADV,
    S_ADV_FIN
  } state_e;

  // classified command handed from front to back
  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  data;
    logic [CNT_W-1:0]   count;
    logic               first;
    logic               over_max;
    logic               zero;
  } cmd_t;

  // one result record, the byte comes straight from the store
  typedef struct packed {
    status_e            status;
    logic               last;
    logic               from_ram;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   free;
    logic [DENQ_W-1:0]  denq;
    logic [CNT_W-1:0]   ddeq;
    logic [CNT_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   wr_idx;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/brbq_ram.sv
// brbq_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
`default_nettype none

module brbq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/brbq_front.sv
// brbq_front: request intake, opcode classification and the command queue
// depends on brbq_pkg
`default_nettype none

module brbq_front #(
  parameter int unsigned MAX_XFER = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [brbq_pkg::OP_W-1:0]     opcode_i,
  input  wire logic [brbq_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic [brbq_pkg::CNT_W-1:0]    xfer_count_i,
  input  wire logic                          first_of_transfer_i,
  output logic                               busy_o,
  output logic                               cmd_valid_o,
  output brbq_pkg::cmd_t                     cmd_o,
  input  wire logic                          cmd_pop_i
);

  localparam int unsigned QAW = (brbq_pkg::CMDQ_DEPTH > 1) ? $clog2(brbq_pkg::CMDQ_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(brbq_pkg::CMDQ_DEPTH + 1);

  brbq_pkg::cmd_t cmd_new;
  brbq_pkg::cmd_t q_mem_q [brbq_pkg::CMDQ_DEPTH];
  logic [QAW-1:0] wptr_q, wptr_d;
  logic [QAW-1:0] rptr_q, rptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push;

  // classify the incoming request
  always_comb begin
    cmd_new          = '0;
    cmd_new.data     = data_byte_i;
    cmd_new.count    = xfer_count_i;
    cmd_new.first    = first_of_transfer_i;
    cmd_new.over_max = xfer_count_i > brbq_pkg::CNT_W'(MAX_XFER);
    cmd_new.zero     = xfer_count_i == '0;
    unique case (brbq_pkg::op_e'(opcode_i))
      brbq_pkg::OP_ENQ:    cmd_new.kind = brbq_pkg::K_ENQ;
      brbq_pkg::OP_DEQ:    cmd_new.kind = brbq_pkg::K_DEQ;
      brbq_pkg::OP_PEEK:   cmd_new.kind = brbq_pkg::K_PEEK;
      brbq_pkg::OP_ADV_WR: cmd_new.kind = brbq_pkg::K_ADV_WR;
      brbq_pkg::OP_ADV_RD: cmd_new.kind = brbq_pkg::K_ADV_RD;
      brbq_pkg::OP_CLEAR:  cmd_new.kind = brbq_pkg::K_CLEAR;
      brbq_pkg::OP_QUERY:  cmd_new.kind = brbq_pkg::K_QUERY;
      default:             cmd_new.kind = brbq_pkg::K_NOP;
    endcase
  end

  // queue control
  assign busy_o      = cnt_q == QCW'(brbq_pkg::CMDQ_DEPTH);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = q_mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QAW'(brbq_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rptr_d = (rptr_q == QAW'(brbq_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

>>> rtl/brbq_back.sv
// brbq_back: executes queued commands against the indexes and the byte store
// depends on brbq_pkg and brbq_ram
`default_nettype none

module brbq_back #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_XFER = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire brbq_pkg::cmd_t               cmd_i,
  output logic                              cmd_pop_o,
  output logic                              res_valid_o,
  output brbq_pkg::res_t                    res_o,
  output logic [brbq_pkg::BYTE_W-1:0]       res_byte_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(MAX_XFER + 1);
  localparam bit          POW2 = (DEPTH & (DEPTH - 1)) == 0;
  localparam logic [AW-1:0] DEPTH_M1 = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
  localparam logic [brbq_pkg::RECIP_W-1:0] RECIP = brbq_pkg::RECIP_W'(
    ((64'd1 << brbq_pkg::RECIP_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  brbq_pkg::state_e state_q, state_d;
  logic [AW-1:0]    rd_pos_q, rd_pos_d;
  logic [AW-1:0]    wr_pos_q, wr_pos_d;
  logic [brbq_pkg::CNT_W-1:0] enq_rem_q, enq_rem_d;
  logic             enq_rej_q, enq_rej_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic             consume_q, consume_d;
  logic [brbq_pkg::ADV_SUM_W-1:0] sum_q, sum_d;
  logic [brbq_pkg::CNT_W-1:0]     quot_q, quot_d;
  logic             adv_wr_q, adv_wr_d;
  logic             res_valid_q, res_valid_d;
  brbq_pkg::res_t   res_q, res_d;

  logic             ram_we, ram_re;
  logic [brbq_pkg::BYTE_W-1:0] ram_rdata;

  logic             wr_ge_rd;
  logic [AW:0]      diff;
  logic [AW-1:0]    used;
  logic [AW-1:0]    free;
  logic [AW:0]      denq;
  logic [AW:0]      ddeq;
  logic [brbq_pkg::CNT_W-1:0] enq_len;
  logic [AW-1:0]    adv_base;
  logic [brbq_pkg::ADV_SUM_W+brbq_pkg::RECIP_W-1:0] adv_mul;
  logic [brbq_pkg::CNT_W+AW:0]    adv_prod;
  logic [brbq_pkg::ADV_SUM_W-1:0] adv_rem;
  logic [AW-1:0]    adv_wrap;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == DEPTH_M1) ? '0 : p + 1'b1;
  endfunction

  // occupancy and contiguous sizes from the two indexes
  always_comb begin
    wr_ge_rd = wr_pos_q >= rd_pos_q;
    diff     = {1'b0, wr_pos_q} - {1'b0, rd_pos_q};
    if (!wr_ge_rd) begin
      diff = diff + DEPTH_X;
    end
    used = diff[AW-1:0];
    free = DEPTH_M1 - used;
    denq = wr_ge_rd ? DEPTH_X - {1'b0, wr_pos_q}
                    : {1'b0, rd_pos_q} - {1'b0, wr_pos_q} - 1'b1;
    ddeq = wr_ge_rd ? {1'b0, wr_pos_q} - {1'b0, rd_pos_q}
                    : DEPTH_X - {1'b0, rd_pos_q};
  end

  // transfer length and index advance helpers
  // advance: quotient by reciprocal multiply, then remainder in the next cycle
  assign enq_len  = cmd_i.first ? cmd_i.count : brbq_pkg::CNT_W'(1);
  assign adv_base = (cmd_i.kind == brbq_pkg::K_ADV_WR) ? wr_pos_q : rd_pos_q;
  assign adv_mul  = sum_q * RECIP;
  assign adv_prod = quot_q * DEPTH_X;
  assign adv_rem  = sum_q - adv_prod[brbq_pkg::ADV_SUM_W-1:0];
  assign adv_wrap = adv_rem[AW-1:0];

  // sequencer: next state and outputs
  always_comb begin
    state_d     = state_q;
    rd_pos_d    = rd_pos_q;
    wr_pos_d    = wr_pos_q;
    enq_rem_d   = enq_rem_q;
    enq_rej_d   = enq_rej_q;
    pos_d       = pos_q;
    rem_d       = rem_q;
    consume_d   = consume_q;
    sum_d       = sum_q;
    quot_d      = quot_q;
    adv_wr_d    = adv_wr_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_q)
      brbq_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind) inside
            brbq_pkg::K_ENQ: begin
              res_valid_d = 1'b1;
              if (cmd_i.first || enq_rem_q == '0) begin
                if (cmd_i.first && cmd_i.zero) begin
                  enq_rem_d = '0;
                  enq_rej_d = 1'b0;
                end else if (enq_len > brbq_pkg::CNT_W'(free)) begin
                  enq_rej_d    = 1'b1;
                  enq_rem_d    = enq_len - 1'b1;
                  res_d.status = brbq_pkg::ST_SHORT;
                end else begin
                  enq_rej_d = 1'b0;
                  enq_rem_d = enq_len - 1'b1;
                  ram_we    = 1'b1;
                  wr_pos_d  = wrap_inc(wr_pos_q);
                end
              end else begin
                enq_rem_d = enq_rem_q - 1'b1;
                if (enq_rej_q) begin
                  res_d.status = brbq_pkg::ST_SHORT;
                end else begin
                  ram_we   = 1'b1;
                  wr_pos_d = wrap_inc(wr_pos_q);
                end
              end
            end
            brbq_pkg::K_DEQ, brbq_pkg::K_PEEK: begin
              if (cmd_i.over_max) begin
                res_valid_d  = 1'b1;
                res_d.status = brbq_pkg::ST_OVER;
              end else if (cmd_i.count > brbq_pkg::CNT_W'(used)) begin
                res_valid_d  = 1'b1;
                res_d.status = brbq_pkg::ST_SHORT;
              end else if (cmd_i.zero) begin
                res_valid_d = 1'b1;
              end else begin
                state_d   = brbq_pkg::S_READ;
                pos_d     = rd_pos_q;
                rem_d     = cmd_i.count[CW-1:0];
                consume_d = cmd_i.kind == brbq_pkg::K_DEQ;
              end
            end
            brbq_pkg::K_ADV_WR, brbq_pkg::K_ADV_RD: begin
              if (POW2) begin
                res_valid_d = 1'b1;
                if (cmd_i.kind == brbq_pkg::K_ADV_WR) begin
                  wr_pos_d = wr_pos_q + cmd_i.count[AW-1:0];
                end else begin
                  rd_pos_d = rd_pos_q + cmd_i.count[AW-1:0];
                end
              end else begin
                state_d  = brbq_pkg::S_ADV;
                sum_d    = brbq_pkg::ADV_SUM_W'(adv_base) +
                           brbq_pkg::ADV_SUM_W'(cmd_i.count);
                adv_wr_d = cmd_i.kind == brbq_pkg::K_ADV_WR;
              end
            end
            brbq_pkg::K_CLEAR: begin
              res_valid_d = 1'b1;
              rd_pos_d    = '0;
              wr_pos_d    = '0;
            end
            brbq_pkg::K_QUERY: begin
              res_valid_d  = 1'b1;
              res_d.used   = brbq_pkg::CNT_W'(used);
              res_d.free   = brbq_pkg::CNT_W'(free);
              res_d.denq   = brbq_pkg::DENQ_W'(denq);
              res_d.ddeq   = brbq_pkg::CNT_W'(ddeq[AW-1:0]);
              res_d.rd_idx = brbq_pkg::CNT_W'(rd_pos_q);
              res_d.wr_idx = brbq_pkg::CNT_W'(wr_pos_q);
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      // one store read per cycle, data lands with the result strobe
      brbq_pkg::S_READ: begin
        ram_re         = 1'b1;
        res_valid_d    = 1'b1;
        res_d.from_ram = 1'b1;
        res_d.last     = rem_q == CW'(1);
        pos_d          = wrap_inc(pos_q);
        rem_d          = rem_q - 1'b1;
        if (rem_q == CW'(1)) begin
          state_d = brbq_pkg::S_IDLE;
          if (consume_q) begin
            rd_pos_d = wrap_inc(pos_q);
          end
        end
      end
      // quotient of index plus count by DEPTH
      brbq_pkg::S_ADV: begin
        quot_d  = adv_mul[brbq_pkg::RECIP_SHIFT +: brbq_pkg::CNT_W];
        state_d = brbq_pkg::S_ADV_FIN;
      end
      brbq_pkg::S_ADV_FIN: begin
        res_valid_d = 1'b1;
        state_d     = brbq_pkg::S_IDLE;
        if (adv_wr_q) begin
          wr_pos_d = adv_wrap;
        end else begin
          rd_pos_d = adv_wrap;
        end
      end
      default: begin
        state_d = brbq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brbq_pkg::S_IDLE;
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      enq_rem_q   <= '0;
      enq_rej_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pos_q    <= rd_pos_d;
      wr_pos_q    <= wr_pos_d;
      enq_rem_q   <= enq_rem_d;
      enq_rej_q   <= enq_rej_d;
      res_valid_q <= res_valid_d;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    rem_q     <= rem_d;
    consume_q <= consume_d;
    sum_q     <= sum_d;
    quot_q    <= quot_d;
    adv_wr_q  <= adv_wr_d;
    res_q     <= res_d;
  end

  // byte store
  brbq_ram #(
    .WIDTH (brbq_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos_q),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign res_byte_o  = res_q.from_ram ? ram_rdata : '0;

endmodule

`default_nettype wire

>>> rtl/byte_ring_buffer_queue.sv
// byte_ring_buffer_queue: top level of the circular byte queue
// depends on brbq_pkg, brbq_front, brbq_back (and brbq_ram through brbq_back)
//
// Usage: a request is taken at a rising edge with start_i high and busy_o low.
// The opcode selects enqueue of one byte, dequeue, peek, advance of either
// index, clear or query. Each result shows on the result ports for one cycle
// with res_valid_o high; the receiver has no way to hold it off. last_o marks
// the final result of a request.
// With the command queue empty, a single-result request passes through the
// command queue entry and then the result register. Dequeue and peek of N
// bytes give N back-to-back results, one per store read in S_READ, and keep
// the executer busy until the last. Queued commands wait behind them.
// Throughput: one enqueue, clear, query or error request per cycle while the
// executer is idle; byte reads are bound by the single store read port, and
// an advance ends in S_IDLE when DEPTH is a power of two, else passes through
// S_ADV and S_ADV_FIN with a reciprocal multiply for the wrap. A two-entry
// command queue sits between intake and executer; busy_o is high while full.
// Reset: both indexes and the transfer tracking go to zero and the queue
// empties. Store contents are undefined until written; there is no clearing
// pass, so requests are taken as soon as reset is released.
`default_nettype none

module byte_ring_buffer_queue #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_XFER = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [brbq_pkg::OP_W-1:0]           opcode_i,
  input  wire logic [brbq_pkg::BYTE_W-1:0]         data_byte_i,
  input  wire logic [brbq_pkg::CNT_W-1:0]          xfer_count_i,
  input  wire logic                                first_of_transfer_i,
  output logic                                     res_valid_o,
  output logic [1:0]                               status_o,
  output logic [brbq_pkg::BYTE_W-1:0]              data_byte_res_o,
  output logic                                     last_o,
  output logic [brbq_pkg::CNT_W-1:0]               used_count_o,
  output logic [brbq_pkg::CNT_W-1:0]               free_count_o,
  output logic [brbq_pkg::DENQ_W-1:0]              direct_enqueue_o,
  output logic [brbq_pkg::CNT_W-1:0]               direct_dequeue_o,
  output logic [brbq_pkg::CNT_W-1:0]               read_index_o,
  output logic [brbq_pkg::CNT_W-1:0]               write_index_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  brbq_pkg::cmd_t cmd;
  brbq_pkg::res_t res;

  // intake and classification
  brbq_front #(
    .MAX_XFER (MAX_XFER)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .opcode_i            (opcode_i),
    .data_byte_i         (data_byte_i),
    .xfer_count_i        (xfer_count_i),
    .first_of_transfer_i (first_of_transfer_i),
    .busy_o              (busy_o),
    .cmd_valid_o         (cmd_valid),
    .cmd_o               (cmd),
    .cmd_pop_i           (cmd_pop)
  );

  // execution
  brbq_back #(
    .DEPTH    (DEPTH),
    .MAX_XFER (MAX_XFER)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res),
    .res_byte_o  (data_byte_res_o)
  );

  assign status_o         = res.status;
  assign last_o           = res.last;
  assign used_count_o     = res.used;
  assign free_count_o     = res.free;
  assign direct_enqueue_o = res.denq;
  assign direct_dequeue_o = res.ddeq;
  assign read_index_o     = res.rd_idx;
  assign write_index_o    = res.wr_idx;

  // a multi-byte read streams without gaps
  a_stream_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |=> res_valid_o)
    else $error("read stream broke before its last byte");

  // only successful reads produce non-final results
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !last_o |-> status_o == brbq_pkg::ST_OK)
    else $error("non-final result carries an error status");

  // error results never carry store data
  a_err_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != brbq_pkg::ST_OK |-> data_byte_res_o == '0)
    else $error("error result carries a data byte");

  // reported indexes stay inside the store
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> read_index_o < DEPTH && write_index_o < DEPTH)
    else $error("reported index outside the store");

endmodule

`default_nettype wire

>>> dv/byte_ring_buffer_queue_check.sv
// byte_ring_buffer_queue_check: predicts and checks every result of the byte ring buffer queue
// depends on brbq_pkg; watches the request and result ports and reports a failure count
// also exports the predicted fill level so that stimulus never reads an unwritten entry
module byte_ring_buffer_queue_check import brbq_pkg::*; #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_XFER = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [CNT_W-1:0]    xfer_count_i,
  input  logic                first_of_transfer_i,
  input  logic                res_valid_i,
  input  logic [1:0]          status_i,
  input  logic [BYTE_W-1:0]   data_byte_res_i,
  input  logic                last_i,
  input  logic [CNT_W-1:0]    used_count_i,
  input  logic [CNT_W-1:0]    free_count_i,
  input  logic [DENQ_W-1:0]   direct_enqueue_i,
  input  logic [CNT_W-1:0]    direct_dequeue_i,
  input  logic [CNT_W-1:0]    read_index_i,
  input  logic [CNT_W-1:0]    write_index_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         held_o,
  output int unsigned         room_o,
  output int unsigned         safe_read_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result
  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [CNT_W-1:0]    used;
    logic [CNT_W-1:0]    free;
    logic [DENQ_W-1:0]   denq;
    logic [CNT_W-1:0]    ddeq;
    logic [CNT_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    wr_idx;
  } outcome_t;

  // predicted queue state
  logic [BYTE_W-1:0] ring [DEPTH];
  bit                written [DEPTH];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  logic [CNT_W-1:0]  xfer_left;
  bit                xfer_drop;
  outcome_t          outcome_q [$];

  function automatic int unsigned held_bytes();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  // bytes from the read index that are known to be written, capped at one transfer
  function automatic int unsigned safe_reads();
    int unsigned n;
    int unsigned lim;
    lim = held_bytes();
    n = 0;
    while (n < lim && n < MAX_XFER && written[(rd_ptr + n) % DEPTH]) n++;
    return n;
  endfunction

  // apply one accepted request and queue the results it causes
  function automatic void run_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] din,
                                      logic [CNT_W-1:0] cnt, logic first);
    outcome_t    r;
    int unsigned len;
    int unsigned pos;
    int unsigned n_used;
    bit          keep;
    bit          multi;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    n_used = held_bytes();
    keep = 1'b0;
    multi = 1'b0;
    case (op)
      OP_ENQ: begin
        if (first || xfer_left == '0) begin
          len = first ? cnt : 1;
          if (len == 0) begin
            xfer_left = '0;
            xfer_drop = 1'b0;
          end else if (len > DEPTH - 1 - n_used) begin
            // whole transfer refused, later bytes dropped
            xfer_drop = 1'b1;
            xfer_left = CNT_W'(len - 1);
            r.status = ST_SHORT;
          end else begin
            xfer_drop = 1'b0;
            xfer_left = CNT_W'(len - 1);
            keep = 1'b1;
          end
        end else begin
          xfer_left = xfer_left - 1'b1;
          if (xfer_drop) r.status = ST_SHORT;
          else keep = 1'b1;
        end
        if (keep) begin
          ring[wr_ptr] = din;
          written[wr_ptr] = 1'b1;
          wr_ptr = (wr_ptr + 1) % DEPTH;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (cnt > MAX_XFER) r.status = ST_OVER;
        else if (cnt > n_used) r.status = ST_SHORT;
        else if (cnt != '0) begin
          multi = 1'b1;
          pos = rd_ptr;
          for (int i = 0; i < cnt; i++) begin
            r.data = ring[pos];
            r.last = (i == cnt - 1);
            outcome_q.push_back(r);
            pos = (pos + 1) % DEPTH;
          end
          if (op == OP_DEQ) rd_ptr = pos;
        end
      end
      OP_ADV_WR: wr_ptr = (wr_ptr + cnt) % DEPTH;
      OP_ADV_RD: rd_ptr = (rd_ptr + cnt) % DEPTH;
      OP_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
      end
      OP_QUERY: begin
        r.used = CNT_W'(n_used);
        r.free = CNT_W'(DEPTH - 1 - n_used);
        if (wr_ptr >= rd_ptr) begin
          r.denq = DENQ_W'(DEPTH - wr_ptr);
          r.ddeq = CNT_W'(wr_ptr - rd_ptr);
        end else begin
          r.denq = DENQ_W'(rd_ptr - wr_ptr - 1);
          r.ddeq = CNT_W'(DEPTH - rd_ptr);
        end
        r.rd_idx = CNT_W'(rd_ptr);
        r.wr_idx = CNT_W'(wr_ptr);
      end
      default: ;
    endcase
    if (!multi) outcome_q.push_back(r);
  endfunction

  // compare one result with the oldest prediction
  function automatic void check_result();
    outcome_t want;
    bit       bad;
    if (outcome_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: result with nothing predicted: status %0d data %02h last %0b",
                 $time, status_i, data_byte_res_i, last_i);
      return;
    end
    want = outcome_q.pop_front();
    bad = (status_i !== want.status) || (data_byte_res_i !== want.data) ||
          (last_i !== want.last) || (used_count_i !== want.used) ||
          (free_count_i !== want.free) || (direct_enqueue_i !== want.denq) ||
          (direct_dequeue_i !== want.ddeq) || (read_index_i !== want.rd_idx) ||
          (write_index_i !== want.wr_idx);
    if (bad) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: result mismatch", $time);
        $display("  exp: st %0d data %02h last %0b used %0d free %0d denq %0d ddeq %0d rd %0d wr %0d",
                 want.status, want.data, want.last, want.used, want.free, want.denq,
                 want.ddeq, want.rd_idx, want.wr_idx);
        $display("  got: st %0d data %02h last %0b used %0d free %0d denq %0d ddeq %0d rd %0d wr %0d",
                 status_i, data_byte_res_i, last_i, used_count_i, free_count_i,
                 direct_enqueue_i, direct_dequeue_i, read_index_i, write_index_i);
      end
    end
  endfunction

  // results first, since a request never answers at its own accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr = 0;
      wr_ptr = 0;
      xfer_left = '0;
      xfer_drop = 1'b0;
      outcome_q.delete();
      foreach (written[i]) written[i] = 1'b0;
      fail_count_o = 0;
    end else begin
      if (res_valid_i) check_result();
      if (start_i && !busy_i)
        run_request(opcode_i, data_byte_i, xfer_count_i, first_of_transfer_i);
    end
    pending_o = outcome_q.size();
    held_o = held_bytes();
    room_o = DEPTH - 1 - held_o;
    safe_read_o = safe_reads();
  end

endmodule

>>> dv/byte_ring_buffer_queue_test.sv
// byte_ring_buffer_queue_test: top of the byte ring buffer queue testbench
// depends on brbq_pkg, byte_ring_buffer_queue and byte_ring_buffer_queue_check
// drives directed then random requests in bursts and gives the verdict
module byte_ring_buffer_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brbq_pkg::*;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned MAX_XFER    = 64;
  localparam int unsigned N_RANDOM    = 460;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 32;
  localparam int unsigned CNT_MAX     = 4095;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     opcode;
  logic [BYTE_W-1:0]   data_byte;
  logic [CNT_W-1:0]    xfer_count;
  logic                first_of_transfer;
  logic                res_valid;
  logic [1:0]          status;
  logic [BYTE_W-1:0]   data_byte_res;
  logic                last;
  logic [CNT_W-1:0]    used_count;
  logic [CNT_W-1:0]    free_count;
  logic [DENQ_W-1:0]   direct_enqueue;
  logic [CNT_W-1:0]    direct_dequeue;
  logic [CNT_W-1:0]    read_index;
  logic [CNT_W-1:0]    write_index;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned held;
  int unsigned room;
  int unsigned safe_rd;
  int unsigned sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  byte_ring_buffer_queue #(
    .DEPTH    (DEPTH),
    .MAX_XFER (MAX_XFER)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_o              (busy),
    .opcode_i            (opcode),
    .data_byte_i         (data_byte),
    .xfer_count_i        (xfer_count),
    .first_of_transfer_i (first_of_transfer),
    .res_valid_o         (res_valid),
    .status_o            (status),
    .data_byte_res_o     (data_byte_res),
    .last_o              (last),
    .used_count_o        (used_count),
    .free_count_o        (free_count),
    .direct_enqueue_o    (direct_enqueue),
    .direct_dequeue_o    (direct_dequeue),
    .read_index_o        (read_index),
    .write_index_o       (write_index)
  );

  byte_ring_buffer_queue_check #(
    .DEPTH    (DEPTH),
    .MAX_XFER (MAX_XFER)
  ) queue_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_i              (busy),
    .opcode_i            (opcode),
    .data_byte_i         (data_byte),
    .xfer_count_i        (xfer_count),
    .first_of_transfer_i (first_of_transfer),
    .res_valid_i         (res_valid),
    .status_i            (status),
    .data_byte_res_i     (data_byte_res),
    .last_i              (last),
    .used_count_i        (used_count),
    .free_count_i        (free_count),
    .direct_enqueue_i    (direct_enqueue),
    .direct_dequeue_i    (direct_dequeue),
    .read_index_i        (read_index),
    .write_index_i       (write_index),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .held_o              (held),
    .room_o              (room),
    .safe_read_o         (safe_rd)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // issue one request at a falling edge, hold it until taken, return at a falling edge
  task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                              input logic [CNT_W-1:0] cnt, input logic first);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    data_byte <= din;
    xfer_count <= cnt;
    first_of_transfer <= first;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  // dequeue or peek with a count that never touches an unwritten entry
  task automatic send_read(input logic [OP_W-1:0] op);
    int unsigned cnt;
    case ($urandom_range(0, 9))
      0: cnt = $urandom_range(MAX_XFER + 1, CNT_MAX);
      1: cnt = (held < MAX_XFER) ? $urandom_range(held + 1, MAX_XFER)
                                 : $urandom_range(MAX_XFER + 1, CNT_MAX);
      2, 3: cnt = safe_rd;
      default: cnt = $urandom_range(0, safe_rd);
    endcase
    send_request(op, BYTE_W'($urandom), CNT_W'(cnt), 1'($urandom_range(0, 1)));
  endtask

  // one transfer: first byte carries the length, some are cut short or interleaved
  task automatic send_transfer();
    int unsigned len;
    int unsigned cut;
    int unsigned side;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) len = 0;
    else if (sel <= 2) len = (room < 4000) ? room + $urandom_range(1, 24) : $urandom_range(1, 24);
    else if (sel == 3) len = $urandom_range(40, 80);
    else len = $urandom_range(1, 20);
    cut = len;
    side = 0;
    // long refused transfers are broken off early, leftover bytes drop later
    if (len > room && len > 8) cut = $urandom_range(1, 6);
    if (len > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, len - 1);
    if (len > 1 && $urandom_range(0, 6) == 0) side = $urandom_range(1, len - 1);
    send_request(OP_ENQ, BYTE_W'($urandom), CNT_W'(len), 1'b1);
    for (int k = 1; k < cut; k++) begin
      if (k == side) begin
        if ($urandom_range(0, 1) == 0)
          send_request(OP_QUERY, BYTE_W'($urandom), CNT_W'($urandom), 1'b0);
        else send_read(OP_PEEK);
      end
      send_request(OP_ENQ, BYTE_W'($urandom), CNT_W'($urandom_range(0, CNT_MAX)), 1'b0);
    end
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned base;
    int unsigned pick;
    rst_n = 1'b0;
    start = 1'b0;
    opcode = OP_QUERY;
    data_byte = '0;
    xfer_count = '0;
    first_of_transfer = 1'b0;
    sent = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty queue, error counts, a short transfer and its readback
    send_request(OP_QUERY, 8'h00, 12'd0, 1'b0);
    send_request(OP_DEQ, 8'h00, 12'd0, 1'b0);
    send_request(OP_PEEK, 8'h00, 12'd1, 1'b0);
    send_request(OP_DEQ, 8'hFF, 12'd4095, 1'b1);
    send_request(OP_DEQ, 8'h00, 12'd65, 1'b0);
    send_request(OP_ENQ, 8'h00, 12'd5, 1'b1);
    send_request(OP_ENQ, 8'hFF, 12'hFFF, 1'b0);
    send_request(OP_ENQ, 8'hA5, 12'h000, 1'b0);
    send_request(OP_ENQ, 8'h5A, 12'h555, 1'b0);
    send_request(OP_ENQ, 8'h01, 12'hAAA, 1'b0);
    send_request(OP_PEEK, 8'h00, 12'd5, 1'b0);
    send_request(OP_DEQ, 8'h00, 12'd3, 1'b0);
    // stray byte, zero-length transfer, refused transfer with dropped bytes
    send_request(OP_ENQ, 8'h3C, 12'd4095, 1'b0);
    send_request(OP_ENQ, 8'h11, 12'd0, 1'b1);
    send_request(OP_ENQ, 8'h77, 12'd4095, 1'b1);
    send_request(OP_ENQ, 8'h88, 12'd1, 1'b0);
    send_request(OP_ENQ, 8'h99, 12'd2, 1'b0);
    send_request(OP_ENQ, 8'h22, 12'd0, 1'b1);
    send_request(OP_DEQ, 8'h00, 12'd3, 1'b0);
    // index moves with wrap, full queue, clear and the unused opcode
    send_request(OP_ADV_RD, 8'h00, 12'd0, 1'b0);
    send_request(OP_ADV_WR, 8'h00, 12'd4095, 1'b0);
    send_request(OP_QUERY, 8'h00, 12'd0, 1'b0);
    send_request(OP_ENQ, 8'h44, 12'd1, 1'b1);
    send_request(OP_ADV_RD, 8'h00, 12'd4095, 1'b0);
    send_request(OP_CLEAR, 8'h00, 12'd0, 1'b0);
    send_request(OP_UNUSED, 8'hFF, 12'hFFF, 1'b1);
    send_request(OP_QUERY, 8'h00, 12'd0, 1'b0);

    // random: mostly well-formed transfers and reads, with index noise
    base = sent;
    while (sent < base + N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_transfer();
      else if (pick < 62) send_read(($urandom_range(0, 4) < 3) ? OP_DEQ : OP_PEEK);
      else if (pick < 72)
        send_request(OP_QUERY, BYTE_W'($urandom), CNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      else if (pick < 80)
        send_request(OP_ADV_RD, BYTE_W'($urandom),
                     CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, CNT_MAX)
                                                        : $urandom_range(0, held)), 1'b0);
      else if (pick < 86)
        send_request(OP_ADV_WR, BYTE_W'($urandom),
                     CNT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, CNT_MAX)
                                                        : $urandom_range(0, 16)), 1'b0);
      else if (pick < 91)
        send_request(OP_CLEAR, BYTE_W'($urandom), CNT_W'($urandom),
                     1'($urandom_range(0, 1)));
      else if (pick < 96)
        send_request(OP_ENQ, BYTE_W'($urandom), CNT_W'($urandom_range(0, CNT_MAX)), 1'b0);
      else
        send_request(OP_UNUSED, BYTE_W'($urandom), CNT_W'($urandom),
                     1'($urandom_range(0, 1)));
    end

    // drain and settle
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
